@@ rtl/core/btoc_pkg.sv @@
// Package: shared constants, time table and channel types for the button output controller.
`timescale 1ns / 1ps

package btoc_pkg;

    localparam logic [7:0]  DEBOUNCE_TICKS   = 8'd10;
    localparam logic [7:0]  LONG_PRESS_TICKS = 8'd250;
    localparam logic [4:0]  TENTH_DIVIDE     = 5'd25;
    localparam logic [15:0] TENTH_MAX        = 16'hFFFF;
    localparam logic [15:0] SOUND_THRESHOLD  = 16'd20;
    localparam logic [4:0]  LIMIT_INDEX_MAX  = 5'd16;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 5;

    localparam logic [CFG_ADDR_W-1:0] REG_SWAP_KEYS       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_INDEX_ONE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_INDEX_TWO = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SOUND_ON_ONE    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SOUND_ON_TWO    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_REMEMBER_ONE    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_REMEMBER_TWO    = 3'd6;

    localparam logic [1:0] TONE_NONE = 2'd0;
    localparam logic [1:0] TONE_OK   = 2'd1;
    localparam logic [1:0] TONE_RISE = 2'd2;
    localparam logic [1:0] TONE_FALL = 2'd3;

    typedef struct packed {
        logic [4:0] limit_index;
        logic       sound_on;
        logic       remember;
    } chan_cfg_t;

    typedef struct packed {
        logic        level;
        logic [4:0]  prescale;
        logic [15:0] tenths;
    } chan_state_t;

    typedef struct packed {
        logic [1:0] tone;
        logic       save;
    } chan_event_t;

    function automatic logic [15:0] limit_of(input logic [4:0] idx);
        logic [15:0] lim;
        case (idx)
            5'd0:    lim = 16'hFFFF;
            5'd1:    lim = 16'd2;
            5'd2:    lim = 16'd5;
            5'd3:    lim = 16'd10;
            5'd4:    lim = 16'd20;
            5'd5:    lim = 16'd300;
            5'd6:    lim = 16'd600;
            5'd7:    lim = 16'd1200;
            5'd8:    lim = 16'd1800;
            5'd9:    lim = 16'd3000;
            5'd10:   lim = 16'd6000;
            5'd11:   lim = 16'd9000;
            5'd12:   lim = 16'd12000;
            5'd13:   lim = 16'd18000;
            5'd14:   lim = 16'd27000;
            5'd15:   lim = 16'd36000;
            default: lim = 16'd54000;
        endcase
        return lim;
    endfunction

endpackage

@@ rtl/core/btoc_channel.sv @@
// Per-output next-state logic: key toggle, tenth timer and auto-off.
`timescale 1ns / 1ps

module btoc_channel (
    input  logic                 toggle,
    input  btoc_pkg::chan_cfg_t   cfg,
    input  btoc_pkg::chan_state_t cur,
    output btoc_pkg::chan_state_t nxt,
    output btoc_pkg::chan_event_t evt
);
    import btoc_pkg::*;

    logic [15:0] lim;
    logic        updown;
    logic        unlimited;
    logic        lvl_key;
    logic [4:0]  pre_key;
    logic [1:0]  tone_key;
    logic        save_key;
    logic [4:0]  pre_tmr;
    logic [15:0] ten_tmr;
    logic        auto_off;

    assign lim       = limit_of(cfg.limit_index);
    assign updown    = lim > SOUND_THRESHOLD;
    assign unlimited = lim == TENTH_MAX;

    always_comb begin
        lvl_key  = cur.level;
        pre_key  = cur.prescale;
        tone_key = TONE_NONE;
        save_key = 1'b0;
        if (toggle) begin
            save_key = cfg.remember && unlimited;
            if (cur.level) begin
                lvl_key  = 1'b0;
                tone_key = (cfg.sound_on && updown) ? TONE_FALL : TONE_NONE;
            end else begin
                lvl_key  = 1'b1;
                pre_key  = 5'd0;
                tone_key = cfg.sound_on ? (updown ? TONE_RISE : TONE_OK) : TONE_NONE;
            end
        end
    end

    always_comb begin
        pre_tmr = pre_key;
        ten_tmr = 16'd0;
        if (lvl_key && (lim != 16'd0)) begin
            ten_tmr = cur.tenths;
            if (pre_key >= TENTH_DIVIDE) begin
                pre_tmr = 5'd0;
                if (cur.tenths != TENTH_MAX) begin
                    ten_tmr = cur.tenths + 16'd1;
                end
            end else begin
                pre_tmr = pre_key + 5'd1;
            end
        end
    end

    assign auto_off = ten_tmr > lim;

    always_comb begin
        nxt.prescale = pre_tmr;
        nxt.tenths   = ten_tmr;
        nxt.level    = lvl_key;
        evt.tone     = tone_key;
        evt.save     = save_key;
        if (auto_off) begin
            nxt.level = 1'b0;
            evt.tone  = (cfg.sound_on && updown) ? TONE_FALL : TONE_NONE;
            evt.save  = save_key || (cfg.remember && unlimited);
        end
    end

endmodule

@@ rtl/core/button_timed_output_controller_unit.sv @@
// Top level: one-button controller for two timed outputs with input and result registers.
// Throughput: one tick per cycle while the result port is not stalled by m_ready low;
// the input register and result register sit on either side of a single pass through
// the press counter and the two channel timers.
// Reset: synchronous, active-low aresetn clears the press counter, timers, output levels,
// configuration registers and both valid flags.
`timescale 1ns / 1ps

module button_timed_output_controller_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [btoc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [btoc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_key_down,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_drive_one,
    output logic                              m_drive_two,
    output logic [1:0]                        m_tone_one,
    output logic [1:0]                        m_tone_two,
    output logic                              m_save_one,
    output logic                              m_save_two
);
    import btoc_pkg::*;

    logic        swap_keys_reg;
    chan_cfg_t   cfg_one_reg;
    chan_cfg_t   cfg_two_reg;

    logic        in_valid_reg;
    logic        key_down_reg;
    logic        advance;

    logic [7:0]  press_ticks_reg;
    logic [7:0]  press_ticks_next;
    logic [7:0]  press_inc;
    logic        long_evt;
    logic        short_evt;

    chan_state_t st_one_reg;
    chan_state_t st_two_reg;
    chan_state_t st_one_next;
    chan_state_t st_two_next;
    chan_event_t ev_one;
    chan_event_t ev_two;
    logic        toggle_one;
    logic        toggle_two;

    logic        m_valid_reg;
    logic        m_drive_one_reg;
    logic        m_drive_two_reg;
    logic [1:0]  m_tone_one_reg;
    logic [1:0]  m_tone_two_reg;
    logic        m_save_one_reg;
    logic        m_save_two_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swap_keys_reg <= 1'b0;
            cfg_one_reg   <= '0;
            cfg_two_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SWAP_KEYS:       swap_keys_reg           <= cfg_wdata[0];
                REG_LIMIT_INDEX_ONE: cfg_one_reg.limit_index <= cfg_wdata;
                REG_LIMIT_INDEX_TWO: cfg_two_reg.limit_index <= cfg_wdata;
                REG_SOUND_ON_ONE:    cfg_one_reg.sound_on    <= cfg_wdata[0];
                REG_SOUND_ON_TWO:    cfg_two_reg.sound_on    <= cfg_wdata[0];
                REG_REMEMBER_ONE:    cfg_one_reg.remember    <= cfg_wdata[0];
                REG_REMEMBER_TWO:    cfg_two_reg.remember    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            key_down_reg <= s_key_down;
        end
    end

    assign press_inc = (press_ticks_reg <= LONG_PRESS_TICKS) ? press_ticks_reg + 8'd1
                                                             : press_ticks_reg;

    always_comb begin
        long_evt         = 1'b0;
        short_evt        = 1'b0;
        press_ticks_next = 8'd0;
        if (key_down_reg) begin
            press_ticks_next = press_inc;
            long_evt         = press_inc == LONG_PRESS_TICKS;
        end else begin
            short_evt = (press_ticks_reg > DEBOUNCE_TICKS)
                     && (press_ticks_reg < LONG_PRESS_TICKS);
        end
    end

    assign toggle_one = swap_keys_reg ? long_evt  : short_evt;
    assign toggle_two = swap_keys_reg ? short_evt : long_evt;

    btoc_channel u_chan_one (
        .toggle (toggle_one),
        .cfg    (cfg_one_reg),
        .cur    (st_one_reg),
        .nxt    (st_one_next),
        .evt    (ev_one)
    );

    btoc_channel u_chan_two (
        .toggle (toggle_two),
        .cfg    (cfg_two_reg),
        .cur    (st_two_reg),
        .nxt    (st_two_next),
        .evt    (ev_two)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_ticks_reg <= 8'd0;
            st_one_reg      <= '0;
            st_two_reg      <= '0;
        end else if (advance) begin
            press_ticks_reg <= press_ticks_next;
            st_one_reg      <= st_one_next;
            st_two_reg      <= st_two_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_drive_one_reg <= st_one_next.level;
            m_drive_two_reg <= st_two_next.level;
            m_tone_one_reg  <= ev_one.tone;
            m_tone_two_reg  <= ev_two.tone;
            m_save_one_reg  <= ev_one.save;
            m_save_two_reg  <= ev_two.save;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_drive_one = m_drive_one_reg;
    assign m_drive_two = m_drive_two_reg;
    assign m_tone_one  = m_tone_one_reg;
    assign m_tone_two  = m_tone_two_reg;
    assign m_save_one  = m_save_one_reg;
    assign m_save_two  = m_save_two_reg;

    a_press_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        press_ticks_reg <= LONG_PRESS_TICKS + 8'd1)
        else $error("press counter beyond saturation");

    a_rise_on: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_tone_one == TONE_RISE) |-> m_drive_one)
        else $error("rising tone on output one while off");

    a_fall_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_tone_two == TONE_FALL) |-> !m_drive_two)
        else $error("falling tone on output two while on");

    a_save_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_save_one |-> cfg_one_reg.remember && (cfg_one_reg.limit_index == 5'd0))
        else $error("save strobe on output one without unlimited remember");

    a_save_two: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_save_two |-> cfg_two_reg.remember && (cfg_two_reg.limit_index == 5'd0))
        else $error("save strobe on output two without unlimited remember");

endmodule

@@ bench/tb.sv @@
// Testbench: random and directed button ticks against a cycle-free model of the two timed outputs.
`timescale 1ns / 1ps

module tb;
    import btoc_pkg::*;

    localparam int TIMEOUT_CYCLES = 200000;
    localparam int TICK_COUNT     = 1050;
    localparam int STEADY_FROM    = 300;
    localparam int STEADY_TO      = 500;
    localparam logic [15:0] OFF_LIMIT [17] = '{
        16'hFFFF, 16'd2, 16'd5, 16'd10, 16'd20, 16'd300, 16'd600, 16'd1200, 16'd1800,
        16'd3000, 16'd6000, 16'd9000, 16'd12000, 16'd18000, 16'd27000, 16'd36000, 16'd54000
    };

    typedef struct packed {
        logic       drive_one;
        logic       drive_two;
        logic [1:0] tone_one;
        logic [1:0] tone_two;
        logic       save_one;
        logic       save_two;
    } levels_t;

    class output_tracker;
        bit          swap_keys;
        bit [4:0]    limit_sel [2];
        bit          sound_on [2];
        bit          remember [2];
        bit [7:0]    press_ticks;
        bit [4:0]    prescale [2];
        bit [15:0]   tenths [2];
        bit          level [2];
        bit [1:0]    tone [2];
        bit          save [2];
        levels_t     expected_levels_q [$];
        int          errors;
        int          checked;
        int          short_presses;
        int          long_presses;
        int          auto_offs;

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SWAP_KEYS:       swap_keys = val[0];
                REG_LIMIT_INDEX_ONE: limit_sel[0] = val;
                REG_LIMIT_INDEX_TWO: limit_sel[1] = val;
                REG_SOUND_ON_ONE:    sound_on[0] = val[0];
                REG_SOUND_ON_TWO:    sound_on[1] = val[0];
                REG_REMEMBER_ONE:    remember[0] = val[0];
                REG_REMEMBER_TWO:    remember[1] = val[0];
                default: ;
            endcase
        endfunction

        function bit [15:0] limit_for(int o);
            bit [4:0] idx;
            idx = (limit_sel[o] > LIMIT_INDEX_MAX) ? LIMIT_INDEX_MAX : limit_sel[o];
            return OFF_LIMIT[idx];
        endfunction

        function void toggle(int o, bit force_off);
            bit [15:0] lim;
            bit        loud;
            lim  = limit_for(o);
            loud = lim > SOUND_THRESHOLD;
            if (force_off || level[o]) begin
                level[o] = 1'b0;
                tone[o]  = (sound_on[o] && loud) ? TONE_FALL : TONE_NONE;
            end else begin
                level[o]    = 1'b1;
                tone[o]     = sound_on[o] ? (loud ? TONE_RISE : TONE_OK) : TONE_NONE;
                prescale[o] = '0;
            end
            if (remember[o] && lim == TENTH_MAX)
                save[o] = 1'b1;
        endfunction

        function void advance_timer(int o);
            bit [15:0] lim;
            lim = limit_for(o);
            if (level[o] && lim != 0) begin
                if (prescale[o] >= TENTH_DIVIDE) begin
                    prescale[o] = '0;
                    if (tenths[o] < TENTH_MAX)
                        tenths[o]++;
                end else begin
                    prescale[o]++;
                end
            end else begin
                tenths[o] = '0;
            end
            if (tenths[o] > lim) begin
                auto_offs++;
                toggle(o, 1'b1);
            end
        endfunction

        function void take_tick(logic key_down);
            levels_t r;
            tone = '{TONE_NONE, TONE_NONE};
            save = '{1'b0, 1'b0};
            if (key_down) begin
                if (press_ticks <= LONG_PRESS_TICKS)
                    press_ticks++;
                if (press_ticks == LONG_PRESS_TICKS) begin
                    long_presses++;
                    toggle(swap_keys ? 0 : 1, 1'b0);
                end
            end else begin
                if (press_ticks > DEBOUNCE_TICKS && press_ticks < LONG_PRESS_TICKS) begin
                    short_presses++;
                    toggle(swap_keys ? 1 : 0, 1'b0);
                end
                press_ticks = '0;
            end
            advance_timer(0);
            advance_timer(1);
            r.drive_one = level[0];
            r.drive_two = level[1];
            r.tone_one  = tone[0];
            r.tone_two  = tone[1];
            r.save_one  = save[0];
            r.save_two  = save[1];
            expected_levels_q.push_back(r);
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void compare_levels(levels_t got);
            levels_t want;
            if (expected_levels_q.size() == 0) begin
                $error("result transfer with no tick outstanding");
                errors++;
                return;
            end
            want = expected_levels_q.pop_front();
            checked++;
            check_field("drive_one", int'(want.drive_one), int'(got.drive_one));
            check_field("drive_two", int'(want.drive_two), int'(got.drive_two));
            check_field("tone_one", int'(want.tone_one), int'(got.tone_one));
            check_field("tone_two", int'(want.tone_two), int'(got.tone_two));
            check_field("save_one", int'(want.save_one), int'(got.save_one));
            check_field("save_two", int'(want.save_two), int'(got.save_two));
        endfunction

        function int pending();
            return expected_levels_q.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_key_down = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_drive_one;
    logic                  m_drive_two;
    logic [1:0]            m_tone_one;
    logic [1:0]            m_tone_two;
    logic                  m_save_one;
    logic                  m_save_two;

    output_tracker tracker = new();
    bit            steady = 1'b0;
    int            cycles = 0;
    int            ticks_sent = 0;

    button_timed_output_controller_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_key_down  (s_key_down),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_drive_one (m_drive_one),
        .m_drive_two (m_drive_two),
        .m_tone_one  (m_tone_one),
        .m_tone_two  (m_tone_two),
        .m_save_one  (m_save_one),
        .m_save_two  (m_save_two)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= TIMEOUT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 28);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.compare_levels({m_drive_one, m_drive_two, m_tone_one, m_tone_two,
                                    m_save_one, m_save_two});
    end

    task automatic send_tick(input logic key);
        steady = (ticks_sent >= STEADY_FROM) && (ticks_sent < STEADY_TO);
        while (!steady && $urandom_range(0, 99) < 28) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_key_down <= key;
        do @(posedge aclk); while (!s_ready);
        tracker.take_tick(key);
        ticks_sent++;
    endtask

    task automatic press(input int hold, input int gap);
        repeat (hold) send_tick(1'b1);
        repeat (gap) send_tick(1'b0);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        tracker.set_reg(idx, val);
    endtask

    task automatic set_config(input bit swap, input bit [4:0] lim_one, input bit [4:0] lim_two,
                              input bit snd_one, input bit snd_two,
                              input bit rem_one, input bit rem_two);
        drain();
        write_reg(REG_SWAP_KEYS, CFG_DATA_W'(swap));
        write_reg(REG_LIMIT_INDEX_ONE, lim_one);
        write_reg(REG_LIMIT_INDEX_TWO, lim_two);
        write_reg(REG_SOUND_ON_ONE, CFG_DATA_W'(snd_one));
        write_reg(REG_SOUND_ON_TWO, CFG_DATA_W'(snd_two));
        write_reg(REG_REMEMBER_ONE, CFG_DATA_W'(rem_one));
        write_reg(REG_REMEMBER_TWO, CFG_DATA_W'(rem_two));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic bit [4:0] pick_limit();
        case ($urandom_range(0, 7))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd2;
            3:       return 5'd3;
            4:       return 5'd4;
            5:       return LIMIT_INDEX_MAX;
            6:       return 5'd31;
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    initial begin
        int target;
        int r;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short auto-off on output 1, saved unlimited output 2
        set_config(1'b0, 5'd1, 5'd0, 1'b1, 1'b1, 1'b0, 1'b1);
        press(10, 3);
        press(11, 3);
        press(249, 2);
        press(260, 10);
        // swapped keys, top and out-of-range limits
        set_config(1'b1, LIMIT_INDEX_MAX, 5'd31, 1'b1, 1'b1, 1'b1, 1'b1);
        press(30, 5);
        press(250, 5);
        press(12, 5);

        while (ticks_sent < TICK_COUNT) begin
            set_config(1'($urandom_range(0, 1)), pick_limit(), pick_limit(),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            target = ticks_sent + $urandom_range(100, 300);
            if (target > TICK_COUNT)
                target = TICK_COUNT;
            while (ticks_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    press($urandom_range(11, 60), $urandom_range(1, 80));
                end else if (r < 70) begin
                    press($urandom_range(250, 258), $urandom_range(1, 20));
                end else if (r < 78) begin
                    case ($urandom_range(0, 4))
                        0:       press(int'(DEBOUNCE_TICKS), $urandom_range(1, 5));
                        1:       press(DEBOUNCE_TICKS + 1, $urandom_range(1, 5));
                        2:       press(LONG_PRESS_TICKS - 1, $urandom_range(1, 5));
                        3:       press(int'(LONG_PRESS_TICKS), $urandom_range(1, 5));
                        default: press(LONG_PRESS_TICKS + 1, $urandom_range(1, 5));
                    endcase
                end else begin
                    repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
                end
            end
        end
        steady = 1'b0;
        drain();

        $display("%0d ticks transferred, %0d results checked over several register settings",
                 ticks_sent, tracker.checked);
        $display("%0d short presses, %0d long presses, %0d timer switch-offs",
                 tracker.short_presses, tracker.long_presses, tracker.auto_offs);
        if (tracker.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/btoc_pkg.sv
rtl/core/btoc_channel.sv
rtl/core/button_timed_output_controller_unit.sv
bench/tb.sv
